// ===== src/greedy_box_suppression_macros.svh =====
// Assertion macros for the port-level checker of the box suppression block.
// No dependencies; included by bare file name.
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define GBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gbs_pkg.sv =====
// Package for the greedy box suppression block: box record, stream layout,
// sequencer states and the request/response records of the overlap unit. No dependencies.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 15;
    localparam int INDEX_W     = 12;
    localparam int THR_W       = 16;
    localparam int AREA_W      = 2 * SIZE_W;
    localparam int UNION_W     = AREA_W + 1;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic [SIZE_W-1:0]         h;
        logic [SIZE_W-1:0]         w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic valid;
        box_t b;
    } iou_req_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic busy;
    } iou_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AREA  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

// ===== src/gbs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gbs_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gbs_iou_unit.sv =====
// Pipelined overlap test: one stored box per cycle against the current box.
// Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_iou_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gbs_pkg::box_t                box_a,
    input  logic [gbs_pkg::AREA_W-1:0]   area_a,
    input  logic [gbs_pkg::THR_W-1:0]    threshold,
    input  gbs_pkg::iou_req_t            req,
    output gbs_pkg::iou_rsp_t            rsp
);
    import gbs_pkg::*;

    localparam int EXT_W = COORD_W + 2;
    localparam int LHS_W = AREA_W + 16;
    localparam int PRD_W = UNION_W + THR_W;

    logic signed [EXT_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [EXT_W-1:0] lo_x, lo_y, hi_x, hi_y, dx, dy;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SIZE_W-1:0]   iw_reg, ih_reg;
    logic [AREA_W-1:0]   area_b1_reg, area_b2_reg, inter2_reg, inter3_reg;
    logic [UNION_W-1:0]  uni3_reg;
    logic [LHS_W-1:0]    lhs4_reg;
    logic [PRD_W-1:0]    prod4_reg;
    logic                uz4_reg;

    // Edges widened so that right and bottom edges cannot wrap.
    always_comb begin
        ax0  = EXT_W'(box_a.x);
        ay0  = EXT_W'(box_a.y);
        ax1  = ax0 + $signed({3'b000, box_a.w});
        ay1  = ay0 + $signed({3'b000, box_a.h});
        bx0  = EXT_W'(req.b.x);
        by0  = EXT_W'(req.b.y);
        bx1  = bx0 + $signed({3'b000, req.b.w});
        by1  = by0 + $signed({3'b000, req.b.h});
        lo_x = (ax0 > bx0) ? ax0 : bx0;
        lo_y = (ay0 > by0) ? ay0 : by0;
        hi_x = (ax1 < bx1) ? ax1 : bx1;
        hi_y = (ay1 < by1) ? ay1 : by1;
        dx   = hi_x - lo_x;
        dy   = hi_y - lo_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // A positive overlap never exceeds the box width, so it fits in SIZE_W bits.
        iw_reg      <= (dx > 0) ? dx[SIZE_W-1:0] : '0;
        ih_reg      <= (dy > 0) ? dy[SIZE_W-1:0] : '0;
        area_b1_reg <= req.b.w * req.b.h;

        inter2_reg  <= iw_reg * ih_reg;
        area_b2_reg <= area_b1_reg;

        uni3_reg    <= UNION_W'(area_a) + UNION_W'(area_b2_reg) - UNION_W'(inter2_reg);
        inter3_reg  <= inter2_reg;

        prod4_reg   <= threshold * uni3_reg;
        lhs4_reg    <= {inter3_reg, 16'h0000};
        uz4_reg     <= (uni3_reg == '0);
    end

    always_comb begin
        rsp.valid = v4_reg;
        rsp.hit   = !uz4_reg && (PRD_W'(lhs4_reg) > prod4_reg);
        rsp.busy  = v1_reg | v2_reg | v3_reg | v4_reg;
    end

endmodule

// ===== src/greedy_box_suppression.sv =====
// Greedy box suppression: one box accepted per pass; the pass scans all kept boxes.
// A new box is taken only once the previous box's result has been loaded into the output
// register; each pass is paced by the single
// pipelined overlap unit fed one stored box per cycle from the store's one read port.
// Reset (aresetn low, synchronous) empties the store by clearing its count, sets the
// threshold to 29491 and drops any pending result; the store RAM itself is not cleared.
`timescale 1ns / 1ps

module greedy_box_suppression #(
    parameter int MAX_KEPT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: box_index, box_x, box_y, box_w, box_h, zero padding
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: frame_start
    input  logic                            s_tuser,
    // m_tdata: keep, kept_index, overflow, zero padding
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]       cfg_data
);
    import gbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_KEPT);

    state_t              state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;
    logic [CW-1:0]       cnt_reg, ptr_reg;
    box_t                box_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [AREA_W-1:0]   area_a_reg;
    logic                hit_reg;
    logic                rd_v_reg;

    logic                m_valid_reg;
    logic                m_keep_reg, m_ovf_reg;
    logic [INDEX_W-1:0]  m_idx_reg;

    logic                s_xfer, rd_en, out_free, keep_now, full_now, wr_en;
    box_t                rd_box, in_box;
    logic [BOX_W-1:0]    rd_data;
    iou_req_t            req;
    iou_rsp_t            rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign rd_en     = (state_reg == ST_SCAN) && (ptr_reg != cnt_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign keep_now  = !hit_reg;
    assign full_now  = (cnt_reg == CNT_FULL);
    assign wr_en     = (state_reg == ST_DONE) && out_free && keep_now && !full_now;

    always_comb begin
        in_box.x = s_tdata[27:12];
        in_box.y = s_tdata[43:28];
        in_box.w = s_tdata[58:44];
        in_box.h = s_tdata[73:59];
    end

    gbs_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (box_reg),
        .re    (rd_en),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_box    = box_t'(rd_data);
    assign req.valid = rd_v_reg;
    assign req.b     = rd_box;

    gbs_iou_unit u_iou (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .box_a     (box_reg),
        .area_a    (area_a_reg),
        .threshold (thr_reg),
        .req       (req),
        .rsp       (rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_xfer) state_next = ST_AREA;
            ST_AREA:  state_next = ST_SCAN;
            ST_SCAN:  if (ptr_reg == cnt_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_v_reg && !rsp.busy) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THR_RESET;
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            hit_reg     <= 1'b0;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= rd_en;
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (s_xfer && s_tuser) begin
                cnt_reg <= '0;
            end else if (wr_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_AREA) begin
                ptr_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (rd_en) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (rsp.valid && rsp.hit) begin
                    hit_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            box_reg <= in_box;
            idx_reg <= s_tdata[INDEX_W-1:0];
        end
        if (state_reg == ST_AREA) begin
            area_a_reg <= box_reg.w * box_reg.h;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_keep_reg <= keep_now;
            m_ovf_reg  <= keep_now && full_now;
            m_idx_reg  <= idx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_ovf_reg, m_idx_reg, m_keep_reg};

endmodule

// ===== src/gbs_checker.sv =====
// Port-level checker for greedy_box_suppression, attached by a bind statement.
// Depends on gbs_pkg and greedy_box_suppression_macros.svh.
`timescale 1ns / 1ps
`include "greedy_box_suppression_macros.svh"

module gbs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gbs_pkg::M_TDATA_W-1:0] m_tdata
);
    import gbs_pkg::*;

    // A stalled result stays offered.
    `GBS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    // The block works on one box at a time: it is busy right after taking one.
    `GBS_ASSERT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
    // Overflow is reported only for a box that survives.
    `GBS_ASSERT(a_ovf_keep, aclk, aresetn, m_tvalid |-> (!m_tdata[13] || m_tdata[0]), "overflow without keep")
    // Coming out of reset the block is empty and ready.
    `GBS_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (.*);

// ===== verif/box_suppression_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the greedy box suppression block: keeps its own kept-box store and
// threshold from the observed transfers and checks every result. Depends on gbs_pkg.

module box_suppression_checker #(
    parameter int MAX_KEPT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gbs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gbs_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]      cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import gbs_pkg::*;

    typedef struct packed {
        logic               keep;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } verdict_t;

    box_t             kept_store [MAX_KEPT];
    int               kept_total;
    logic [THR_W-1:0] threshold;
    verdict_t         awaited_verdicts [$];
    int               error_count;

    // True when the IoU of the two boxes exceeds the threshold, using the
    // cross-multiplied compare so that no division is needed.
    function automatic bit boxes_clash(box_t a, box_t b, logic [THR_W-1:0] thr);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint x0, y0, x1, y1, inter, uni, t;
        ax = $signed(a.x);
        ay = $signed(a.y);
        aw = a.w;
        ah = a.h;
        bx = $signed(b.x);
        by = $signed(b.y);
        bw = b.w;
        bh = b.h;
        t  = thr;
        x0 = (ax > bx) ? ax : bx;
        y0 = (ay > by) ? ay : by;
        x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
        inter = (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 0;
        uni = aw * ah + bw * bh - inter;
        // Two boxes without area never suppress each other.
        if (uni == 0)
            return 1'b0;
        return inter * 65536 > t * uni;
    endfunction

    function automatic verdict_t judge_box(logic first, logic [INDEX_W-1:0] idx, box_t b);
        verdict_t v;
        v.keep     = 1'b1;
        v.index    = idx;
        v.overflow = 1'b0;
        if (first)
            kept_total = 0;
        for (int j = 0; j < kept_total; j++) begin
            if (boxes_clash(b, kept_store[j], threshold))
                v.keep = 1'b0;
        end
        if (v.keep) begin
            if (kept_total >= MAX_KEPT) begin
                v.overflow = 1'b1;
            end else begin
                kept_store[kept_total] = b;
                kept_total++;
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin : scoreboard
        verdict_t got;
        verdict_t want;
        verdict_t fresh;
        if (!aresetn) begin
            awaited_verdicts.delete();
            kept_total = 0;
            threshold = THR_RESET;
        end else begin
            // Results are handled before inputs so that a result never matches
            // a box accepted at the same edge.
            if (m_tvalid && m_tready) begin
                got.keep     = m_tdata[0];
                got.index    = m_tdata[INDEX_W:1];
                got.overflow = m_tdata[INDEX_W+1];
                if (awaited_verdicts.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("checker: %0t unexpected keep=%0d index=%0d overflow=%0d",
                                 $time, got.keep, got.index, got.overflow);
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.keep !== want.keep || got.index !== want.index ||
                        got.overflow !== want.overflow) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("checker: %0t mismatch want %0d/%0d/%0d got %0d/%0d/%0d",
                                     $time, want.keep, want.index, want.overflow,
                                     got.keep, got.index, got.overflow);
                    end
                end
            end
            // The box fields sit right above box_index in the same order as box_t.
            if (s_tvalid && s_tready) begin
                fresh = judge_box(s_tuser, s_tdata[INDEX_W-1:0], s_tdata[INDEX_W +: BOX_W]);
                awaited_verdicts.insert(awaited_verdicts.size(), fresh);
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
        end
        mismatches  <= error_count;
        outstanding <= awaited_verdicts.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the box suppression testbench: clock, reset, box and threshold stimulus,
// result sink and verdict. Depends on gbs_pkg, greedy_box_suppression and the checker.

module testbench;
    import gbs_pkg::*;

    localparam int MAX_KEPT    = 64;
    localparam int PHASE_ITEMS = 215;
    localparam int QUIET_LIMIT = 20000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [THR_W-1:0]     cfg_data  = '0;

    int mismatches;
    int outstanding;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_cycles  = 0;
    int quiet_cycles = 0;

    greedy_box_suppression #(
        .MAX_KEPT (MAX_KEPT)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    box_suppression_checker #(
        .MAX_KEPT (MAX_KEPT)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 aclk = ~aclk;

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Offers one box and returns at the edge of its transfer. The valid stays
    // high so that a following box can go out back to back.
    task automatic offer_box(input logic fs, input logic [INDEX_W-1:0] idx,
                             input int x, input int y, input int w, input int h);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fs;
        s_tdata  <= {6'b0, h[SIZE_W-1:0], w[SIZE_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0], idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every box has its result, then lets the block settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result sink: random stalls, plus one long hold-off that fills the block up.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int               phase, phase_items, frames, k, n, r, j;
        int               x, y, w, h, cx, cy, base_idx;
        bit               grid, fs;
        logic [THR_W-1:0] thr;
        box_t             prev;
        box_t             hist [$];

        frames = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed boxes under the reset threshold.
        offer_box(1'b1, 12'd0,    -32768, -32768, 32767, 32767);
        offer_box(1'b0, 12'd4095, -32768, -32768, 32767, 32767);  // identical, dropped
        offer_box(1'b0, 12'd1,     32767,  32767, 32767, 32767);
        offer_box(1'b0, 12'd2,       100,    100,     0,     0);
        offer_box(1'b0, 12'd3,       100,    100,     0,     0);  // no area at all
        offer_box(1'b0, 12'd4,       200,    200,     0,    80);
        offer_box(1'b0, 12'd5,       200,    200,     0,    80);
        offer_box(1'b0, 12'd6,      1000,   1000,   160,   160);
        offer_box(1'b0, 12'd7,      1160,   1000,   160,   160);  // shares an edge only
        offer_box(1'b0, 12'd8,      1000,   1160,   160,   160);
        offer_box(1'b0, 12'd9,      2000,   2000,   100,   100);
        offer_box(1'b0, 12'd10,     2010,   2000,   100,   100);
        offer_box(1'b0, 12'd11,     2060,   2000,   100,   100);
        offer_box(1'b0, 12'd12,     -500,   -700,   300,   300);
        offer_box(1'b1, 12'd13,     2000,   2000,   100,   100);
        // With a zero threshold a single shared pixel suppresses.
        write_threshold(16'd0);
        offer_box(1'b0, 12'd14,     2099,   2099,   100,   100);
        offer_box(1'b0, 12'd15,     2100,   2000,   100,   100);
        // At the top threshold only a near-perfect overlap suppresses.
        write_threshold(16'd65535);
        offer_box(1'b0, 12'd16,     2000,   2000,   100,   100);
        offer_box(1'b0, 12'd17,     2000,   2000,   100,    99);
        offer_box(1'b0, 12'd18,   -32768,  32767, 32767,     0);

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       thr = THR_RESET;
                1:       thr = 16'd0;
                2:       thr = 16'd65535;
                4:       thr = THR_W'($urandom_range(49152, 16384));
                5:       thr = 16'd1;
                6:       thr = 16'd65534;
                default: thr = THR_W'($urandom);
            endcase
            write_threshold(thr);
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 85; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (phase == 4)
                hold_cycles = 600;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                // Grid frames hold disjoint boxes, some repeated past the 64th, and overrun the store.
                grid = (frames == 0) || ($urandom_range(9) == 0);
                n = grid ? $urandom_range(72, 66) : $urandom_range(24, 1);
                cx = int'($urandom_range(48000)) - 24000;
                cy = int'($urandom_range(48000)) - 24000;
                base_idx = $urandom_range(4095);
                hist.delete();
                for (k = 0; k < n; k++) begin
                    fs = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
                    r = $urandom_range(99);
                    if (grid && k >= 64 && r >= 50) begin
                        prev = hist[$urandom_range(63)];
                        x = $signed(prev.x);
                        y = $signed(prev.y);
                        w = int'(prev.w);
                        h = int'(prev.h);
                    end else if (grid) begin
                        x = -28800 + (k % 9) * 6400;
                        y = -28800 + ((k / 9) % 8) * 6400;
                        w = $urandom_range(6000, 16);
                        h = $urandom_range(6000, 16);
                    end else if (hist.size() != 0 && r < 50) begin
                        // A jittered copy of an earlier box of this frame.
                        prev = hist[$urandom_range(hist.size() - 1)];
                        j = int'(prev.w) / 3 + 1;
                        x = clip($signed(prev.x) + int'($urandom_range(2 * j)) - j,
                                 -32768, 32767);
                        j = int'(prev.h) / 3 + 1;
                        y = clip($signed(prev.y) + int'($urandom_range(2 * j)) - j,
                                 -32768, 32767);
                        w = clip(int'(prev.w) + int'($urandom_range(int'(prev.w) / 2))
                                 - int'(prev.w) / 4, 0, 32767);
                        h = clip(int'(prev.h) + int'($urandom_range(int'(prev.h) / 2))
                                 - int'(prev.h) / 4, 0, 32767);
                    end else if (r < 90) begin
                        x = clip(cx + int'($urandom_range(8000)) - 4000, -32768, 32767);
                        y = clip(cy + int'($urandom_range(8000)) - 4000, -32768, 32767);
                        w = $urandom_range(4000, 16);
                        h = $urandom_range(4000, 16);
                    end else begin
                        x = int'($urandom_range(65535)) - 32768;
                        y = int'($urandom_range(65535)) - 32768;
                        w = $urandom_range(32767);
                        h = $urandom_range(32767);
                        base_idx = $urandom_range(4095) - k;
                    end
                    offer_box(fs, INDEX_W'(base_idx + k), x, y, w, h);
                    prev.x = x[COORD_W-1:0];
                    prev.y = y[COORD_W-1:0];
                    prev.w = w[SIZE_W-1:0];
                    prev.h = h[SIZE_W-1:0];
                    hist.insert(hist.size(), prev);
                    phase_items++;
                end
                frames++;
            end
        end

        settle();
        repeat (MAX_KEPT + 16) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
